[hdl/lphs_pkg.sv]
// Shared types and constants for the linear probing hash set.
`timescale 1ns / 1ps

package lphs_pkg;

  localparam int SLOT_BITS  = 10;
  localparam int ROW_BITS   = 11;
  localparam int SLOT_COUNT = 1 << SLOT_BITS;
  localparam int KEY_W      = 64;
  localparam int HASH_W     = 64;
  localparam int ROW_W      = 11;
  localparam int COUNT_W    = 11;
  localparam int STATUS_W   = 3;
  localparam int CFG_DATA_W = 2;
  localparam int CFG_IDX_W  = 1;

  // Most distinct keys held: three quarters of the slots
  localparam logic [SLOT_BITS-1:0] LOAD_LIMIT =
    SLOT_BITS'(SLOT_COUNT - SLOT_COUNT / 4);

  localparam logic [ROW_W-1:0] ROW_MASK = ROW_W'((64'd1 << ROW_BITS) - 64'd1);

  localparam logic [CFG_IDX_W-1:0] CFG_PHASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_KWIDTH = 1'b1;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_PROBE  = 1'b1;

  typedef enum logic [1:0] {
    KW_8  = 2'd0,
    KW_16 = 2'd1,
    KW_32 = 2'd2,
    KW_64 = 2'd3
  } kw_code_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_NULL      = 3'd4,
    ST_FULL      = 3'd5,
    ST_PHASE     = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SEARCH,
    S_HOLD
  } state_t;

  typedef struct packed {
    logic start;
    logic clr_write;
    logic step;
    logic finish;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic in_imm;
    logic srch_done;
    logic out_free;
  } dp_stat_t;

endpackage

[hdl/lphs_in_if.sv]
// Input channel interface: one insert or probe item per transfer.
`timescale 1ns / 1ps

interface lphs_in_if;
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic [lphs_pkg::KEY_W-1:0]       key_value;
  logic [lphs_pkg::HASH_W-1:0]      key_hash;
  logic                             key_is_null;
  logic [lphs_pkg::ROW_W-1:0]       row_index;

  modport source (output valid, kind, key_value, key_hash, key_is_null, row_index,
                  input ready);
  modport sink   (input valid, kind, key_value, key_hash, key_is_null, row_index,
                  output ready);
endinterface

[hdl/lphs_out_if.sv]
// Result channel interface: one result per transfer.
`timescale 1ns / 1ps

interface lphs_out_if;
  logic                             valid;
  logic                             ready;
  logic [lphs_pkg::ROW_W-1:0]       row_echo;
  logic [lphs_pkg::STATUS_W-1:0]    status;
  logic [lphs_pkg::COUNT_W-1:0]     stored_count;

  modport source (output valid, row_echo, status, stored_count, input ready);
  modport sink   (input valid, row_echo, status, stored_count, output ready);
endinterface

[hdl/lphs_ctrl.sv]
// Controller state machine: clearing pass, item intake, probe walk, result hand-off.
`timescale 1ns / 1ps

module lphs_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lphs_pkg::dp_stat_t    stat,
  output lphs_pkg::ctrl_cmd_t   cmd
);

  lphs_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lphs_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      lphs_pkg::S_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (stat.clr_done) state_nxt = lphs_pkg::S_IDLE;
      end
      lphs_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          // phase errors and null rows skip the table entirely
          state_nxt = stat.in_imm ? lphs_pkg::S_HOLD : lphs_pkg::S_SEARCH;
        end
      end
      lphs_pkg::S_SEARCH: begin
        if (stat.srch_done) begin
          cmd.finish = 1'b1;
          if (stat.out_free) begin
            cmd.out_load = 1'b1;
            state_nxt    = lphs_pkg::S_IDLE;
          end else begin
            state_nxt = lphs_pkg::S_HOLD;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      lphs_pkg::S_HOLD: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = lphs_pkg::S_IDLE;
        end
      end
      default: state_nxt = lphs_pkg::S_CLEAR;
    endcase
  end

endmodule

[hdl/lphs_dp.sv]
// Datapath: configuration, item registers, slot table, probe address, count, result register.
`timescale 1ns / 1ps

module lphs_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [lphs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lphs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_kind,
  input  logic [lphs_pkg::KEY_W-1:0]          in_key_value,
  input  logic [lphs_pkg::HASH_W-1:0]         in_key_hash,
  input  logic                                in_key_is_null,
  input  logic [lphs_pkg::ROW_W-1:0]          in_row_index,
  input  lphs_pkg::ctrl_cmd_t                 cmd,
  output lphs_pkg::dp_stat_t                  stat,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [lphs_pkg::ROW_W-1:0]          out_row_echo,
  output logic [lphs_pkg::STATUS_W-1:0]       out_status,
  output logic [lphs_pkg::COUNT_W-1:0]        out_stored_count
);

  localparam int SB    = lphs_pkg::SLOT_BITS;
  localparam int MEM_W = 1 + lphs_pkg::HASH_W + lphs_pkg::KEY_W;

  // configuration
  logic                 phase_r;
  lphs_pkg::kw_code_t   kwc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      kwc_r   <= lphs_pkg::KW_64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lphs_pkg::CFG_PHASE:  phase_r <= cfg_wdata[0];
        lphs_pkg::CFG_KWIDTH: kwc_r   <= lphs_pkg::kw_code_t'(cfg_wdata[1:0]);
        default: ;
      endcase
    end
  end

  logic [lphs_pkg::KEY_W-1:0] key_masked;

  always_comb begin
    case (kwc_r)
      lphs_pkg::KW_8:  key_masked = {56'd0, in_key_value[7:0]};
      lphs_pkg::KW_16: key_masked = {48'd0, in_key_value[15:0]};
      lphs_pkg::KW_32: key_masked = {32'd0, in_key_value[31:0]};
      default:         key_masked = in_key_value;
    endcase
  end

  // item registers
  logic                         kind_r;
  logic [lphs_pkg::KEY_W-1:0]   key_r;
  logic [lphs_pkg::HASH_W-1:0]  hash_r;
  logic [lphs_pkg::ROW_W-1:0]   row_r;
  lphs_pkg::status_t            res_st_r;

  logic              in_phase_bad;
  lphs_pkg::status_t srch_st;

  assign in_phase_bad = (in_kind != phase_r);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      kind_r   <= in_kind;
      key_r    <= key_masked;
      hash_r   <= in_key_hash;
      row_r    <= in_row_index & lphs_pkg::ROW_MASK;
      res_st_r <= in_phase_bad ? lphs_pkg::ST_PHASE : lphs_pkg::ST_NULL;
    end else if (cmd.finish) begin
      res_st_r <= srch_st;
    end
  end

  // probe walk
  logic [SB-1:0] addr_r, addr_nxt;
  logic [SB-1:0] visits_r;
  logic [SB-1:0] clr_addr_r;

  always_comb begin
    if (cmd.start) begin
      addr_nxt = in_key_hash[SB-1:0];
    end else if (cmd.step) begin
      addr_nxt = addr_r + 1'b1;
    end else begin
      addr_nxt = addr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r     <= '0;
      visits_r   <= '0;
      clr_addr_r <= '0;
    end else begin
      addr_r <= addr_nxt;
      if (cmd.start) begin
        visits_r <= '0;
      end else if (cmd.step) begin
        visits_r <= visits_r + 1'b1;
      end
      if (cmd.clr_write) clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  // slot table: {used, hash, key}
  logic [MEM_W-1:0] mem [lphs_pkg::SLOT_COUNT];
  logic [MEM_W-1:0] rd_q_r;
  logic             mem_we;
  logic [SB-1:0]    wr_addr;
  logic [MEM_W-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    rd_q_r <= mem[addr_nxt];
  end

  logic                         rd_used;
  logic [lphs_pkg::HASH_W-1:0]  rd_hash;
  logic [lphs_pkg::KEY_W-1:0]   rd_key;
  logic                         rd_match;
  logic                         last_slot;

  assign rd_used   = rd_q_r[MEM_W-1];
  assign rd_hash   = rd_q_r[lphs_pkg::HASH_W + lphs_pkg::KEY_W - 1 -: lphs_pkg::HASH_W];
  assign rd_key    = rd_q_r[lphs_pkg::KEY_W-1:0];
  assign rd_match  = rd_used && (rd_hash == hash_r) && (rd_key == key_r);
  assign last_slot = &visits_r;

  // key count
  logic [SB-1:0] cnt_r, cnt_nxt;
  logic          do_insert;

  always_comb begin
    if (rd_match) begin
      srch_st = (kind_r == lphs_pkg::KIND_PROBE) ? lphs_pkg::ST_FOUND
                                                 : lphs_pkg::ST_DUPLICATE;
    end else if (kind_r == lphs_pkg::KIND_PROBE) begin
      srch_st = lphs_pkg::ST_NOT_FOUND;
    end else if (!rd_used && (cnt_r != lphs_pkg::LOAD_LIMIT)) begin
      srch_st = lphs_pkg::ST_INSERTED;
    end else begin
      // load limit reached, or every slot visited without a free one
      srch_st = lphs_pkg::ST_FULL;
    end
  end

  assign do_insert = cmd.finish && (srch_st == lphs_pkg::ST_INSERTED);
  assign cnt_nxt   = do_insert ? cnt_r + 1'b1 : cnt_r;

  assign mem_we  = cmd.clr_write || do_insert;
  assign wr_addr = cmd.clr_write ? clr_addr_r : addr_r;
  assign wr_data = cmd.clr_write ? '0 : {1'b1, hash_r, key_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // result register
  logic                            out_valid_r;
  logic [lphs_pkg::ROW_W-1:0]      out_row_r;
  logic [lphs_pkg::STATUS_W-1:0]   out_status_r;
  logic [lphs_pkg::COUNT_W-1:0]    out_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_row_r    <= row_r;
      out_status_r <= cmd.finish ? srch_st : res_st_r;
      out_count_r  <= lphs_pkg::COUNT_W'(cnt_nxt);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_row_echo     = out_row_r;
  assign out_status       = out_status_r;
  assign out_stored_count = out_count_r;

  assign stat.clr_done  = &clr_addr_r;
  assign stat.in_imm    = in_phase_bad || in_key_is_null;
  assign stat.srch_done = !rd_used || rd_match || last_slot;
  assign stat.out_free  = !out_valid_r || out_ready;

  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= lphs_pkg::LOAD_LIMIT)
    else $error("key count above load limit");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    do_insert |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("insert did not raise key count");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before transfer");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (cmd.clr_write || cmd.finish))
    else $error("table written outside clearing or commit");

endmodule

[hdl/linear_probe_hash_set_core.sv]
// Top level of the linear probing hash set: controller plus datapath.
//
//   channel   direction  transfer                    payload
//   in_ch     sink       in_ch.valid & in_ch.ready   kind, key_value, key_hash, key_is_null,
//                                                    row_index
//   out_ch    source     out_ch.valid & out_ch.ready row_echo, status, stored_count
//   cfg_*     write      cfg_we                      cfg_index, cfg_wdata
//
// A table item walks its probe chain with one slot read per cycle (the slot table has a
// read port and a separate write port); phase errors and null rows skip the table. After
// reset a clearing pass writes all 2^SLOT_BITS (1024) slots before the first item is
// taken. The result register frees the input side: a new item is taken while the previous
// result still waits; a search that finishes against a stalled output parks until the
// result register is free.
`timescale 1ns / 1ps

module linear_probe_hash_set_core (
  input  logic                                clk,
  input  logic                                rst_n,
  lphs_in_if.sink                             in_ch,
  lphs_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [lphs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lphs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  lphs_pkg::ctrl_cmd_t cmd;
  lphs_pkg::dp_stat_t  stat;
  logic                in_ready;

  assign in_ch.ready = in_ready;

  lphs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lphs_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_kind          (in_ch.kind),
    .in_key_value     (in_ch.key_value),
    .in_key_hash      (in_ch.key_hash),
    .in_key_is_null   (in_ch.key_is_null),
    .in_row_index     (in_ch.row_index),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_row_echo     (out_ch.row_echo),
    .out_status       (out_ch.status),
    .out_stored_count (out_ch.stored_count)
  );

endmodule

[verif/linear_probe_hash_set_core_test.sv]
// Self-checking testbench for the linear probing hash set core: directed and random traffic.
`timescale 1ns / 1ps

module linear_probe_hash_set_core_test;
  import lphs_pkg::*;

  localparam int KEY_CAP     = SLOT_COUNT - SLOT_COUNT / 4;
  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int BUILD_ITEMS = 200;
  localparam int PROBE_ITEMS = 90;
  localparam int ROUNDS      = 12;
  localparam int SHOWN_MAX   = 10;

  typedef struct {
    logic              kind;
    logic [KEY_W-1:0]  key;
    logic [HASH_W-1:0] hash;
    logic              is_null;
    logic [ROW_W-1:0]  row;
  } set_item_t;

  typedef struct {
    logic [ROW_W-1:0]   row;
    status_t            status;
    logic [COUNT_W-1:0] count;
  } set_answer_t;

  // Shadow copy of the slot table; answers are queued in transfer order.
  class set_result_board;
    logic              phase;
    kw_code_t          width;
    bit                used [SLOT_COUNT];
    logic [HASH_W-1:0] stored_hash [SLOT_COUNT];
    logic [KEY_W-1:0]  stored_key [SLOT_COUNT];
    int                key_total;
    set_answer_t       awaited [$];
    int                fails;

    function new();
      phase     = 1'b0;
      width     = KW_64;
      key_total = 0;
      fails     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_PHASE) begin
        phase = data[0];
      end else if (idx == CFG_KWIDTH) begin
        width = kw_code_t'(data);
      end
    endfunction

    function logic [KEY_W-1:0] trim_key(logic [KEY_W-1:0] k);
      case (width)
        KW_8:    return {56'd0, k[7:0]};
        KW_16:   return {48'd0, k[15:0]};
        KW_32:   return {32'd0, k[31:0]};
        default: return k;
      endcase
    endfunction

    // Linear walk from the home slot; slot is the match, the first free slot, or SLOT_COUNT.
    function bit walk_chain(logic [KEY_W-1:0] k, logic [HASH_W-1:0] h, output int slot);
      int pos;
      int n;
      pos = int'(h[SLOT_BITS-1:0]);
      for (n = 0; n < SLOT_COUNT; n++) begin
        if (!used[pos]) begin
          slot = pos;
          return 1'b0;
        end
        if (stored_hash[pos] == h && stored_key[pos] == k) begin
          slot = pos;
          return 1'b1;
        end
        pos = (pos + 1) % SLOT_COUNT;
      end
      slot = SLOT_COUNT;
      return 1'b0;
    endfunction

    function void note_item(set_item_t it);
      set_answer_t      a;
      logic [KEY_W-1:0] k;
      int               slot;
      bit               hit;
      k = trim_key(it.key);
      if (it.kind != phase) begin
        a.status = ST_PHASE;
      end else if (it.is_null) begin
        a.status = ST_NULL;
      end else if (it.kind == KIND_INSERT) begin
        hit = walk_chain(k, it.hash, slot);
        if (hit) begin
          a.status = ST_DUPLICATE;
        end else if (key_total + 1 > KEY_CAP || slot >= SLOT_COUNT) begin
          a.status = ST_FULL;
        end else begin
          used[slot]        = 1'b1;
          stored_hash[slot] = it.hash;
          stored_key[slot]  = k;
          key_total++;
          a.status = ST_INSERTED;
        end
      end else begin
        hit = walk_chain(k, it.hash, slot);
        a.status = hit ? ST_FOUND : ST_NOT_FOUND;
      end
      a.row   = it.row & ROW_MASK;
      a.count = COUNT_W'(key_total);
      awaited.insert(awaited.size(), a);
    endfunction

    function void check_result(logic [ROW_W-1:0] row, logic [STATUS_W-1:0] status,
                               logic [COUNT_W-1:0] count);
      set_answer_t a;
      if (awaited.size() == 0) begin
        fails++;
        if (fails <= SHOWN_MAX)
          $display("unexpected result: row %0d status %0d count %0d", row, status, count);
        return;
      end
      a = awaited.pop_front();
      if (row !== a.row || status !== a.status || count !== a.count) begin
        fails++;
        if (fails <= SHOWN_MAX)
          $display("mismatch: row exp %0d got %0d, status exp %0d got %0d, count exp %0d got %0d",
                   a.row, row, a.status, status, a.count, count);
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    gap_pct;
  int                    stall_pct;
  int                    cycle_count = 0;
  set_result_board       board;
  logic [KEY_W-1:0]      known_key [$];
  logic [HASH_W-1:0]     known_hash [$];

  lphs_in_if  in_ch ();
  lphs_out_if out_ch ();

  linear_probe_hash_set_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: check each transfer, then pick next cycle's ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready)
        board.check_result(out_ch.row_echo, out_ch.status, out_ch.stored_count);
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic set_item_t mk(logic kind, logic [KEY_W-1:0] key, logic [HASH_W-1:0] hash,
                                   logic is_null, logic [ROW_W-1:0] row);
    set_item_t it;
    it.kind    = kind;
    it.key     = key;
    it.hash    = hash;
    it.is_null = is_null;
    it.row     = row;
    return it;
  endfunction

  // A share of hashes land at the top of the table so chains wrap round
  function automatic logic [HASH_W-1:0] fresh_hash();
    logic [HASH_W-1:0] h;
    h = {$urandom, $urandom};
    if ($urandom_range(99) < 30)
      h[SLOT_BITS-1:0] = SLOT_BITS'(SLOT_COUNT - 8 + $urandom_range(7));
    return h;
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    if ($urandom_range(99) < 10)
      return KEY_W'($urandom_range(3));
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ROW_W-1:0] rand_row();
    int p;
    p = $urandom_range(99);
    if (p < 5)
      return '0;
    if (p < 10)
      return '1;
    return ROW_W'($urandom_range(2047));
  endfunction

  task automatic set_idle(input int mode);
    case (mode)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 79; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 79; end
      default: begin gap_pct = 9; stall_pct = 9; end
    endcase
  endtask

  task automatic send_item(input set_item_t it);
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= it.kind;
    in_ch.key_value   <= it.key;
    in_ch.key_hash    <= it.hash;
    in_ch.key_is_null <= it.is_null;
    in_ch.row_index   <= it.row;
    do @(posedge clk); while (!in_ch.ready);
    board.note_item(it);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.pending() != 0)
      @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic run_directed();
    set_idle(0);
    // wrong phase takes precedence over a null key; first transfer waits out the clear
    send_item(mk(KIND_PROBE, '0, '0, 1'b1, '0));
    drain();
    write_reg(CFG_PHASE, 2'b11);
    send_item(mk(KIND_PROBE, '1, '1, 1'b0, '1));          // empty set
    send_item(mk(KIND_INSERT, 64'd5, 64'd5, 1'b0, 11'd1));
    send_item(mk(KIND_PROBE, 64'd5, 64'd5, 1'b1, 11'd2));
    drain();
    write_reg(CFG_PHASE, 2'b10);
    send_item(mk(KIND_INSERT, '0, '0, 1'b0, 11'd3));
    send_item(mk(KIND_INSERT, '1, '1, 1'b0, 11'd4));      // top slot
    send_item(mk(KIND_INSERT, 64'd7, '1, 1'b0, 11'd5));   // wraps past slot 0
    send_item(mk(KIND_INSERT, '1, '0, 1'b0, 11'd6));      // same key, other hash
    send_item(mk(KIND_INSERT, '1, '1, 1'b0, 11'd7));
    send_item(mk(KIND_INSERT, 64'd7, '1, 1'b1, 11'd8));
    send_item(mk(KIND_PROBE, 64'd7, '1, 1'b0, 11'd9));
    drain();
    write_reg(CFG_KWIDTH, KW_8);
    send_item(mk(KIND_INSERT, 64'h1234_5678_9abc_de07, '1, 1'b0, 11'd10));
    send_item(mk(KIND_INSERT, 64'h0000_0000_0000_ff00, '0, 1'b0, 11'd11));
    drain();
    write_reg(CFG_PHASE, 2'b01);
    send_item(mk(KIND_PROBE, '1, '1, 1'b0, 11'd12));      // trimmed key no longer matches
    drain();
    write_reg(CFG_KWIDTH, KW_64);
    send_item(mk(KIND_PROBE, '1, '1, 1'b0, 11'd13));
    send_item(mk(KIND_PROBE, 64'd7, '1, 1'b0, 11'd14));
    send_item(mk(KIND_PROBE, '1, '0, 1'b0, 11'd15));
    send_item(mk(KIND_PROBE, 64'd8, 64'd5, 1'b0, 11'd16));
    drain();
    write_reg(CFG_KWIDTH, KW_16);
    send_item(mk(KIND_PROBE, 64'h0000_0000_abcd_0000, '0, 1'b0, 11'd17));
    drain();
    write_reg(CFG_KWIDTH, KW_32);
    send_item(mk(KIND_PROBE, 64'hffff_ffff_0000_0000, '0, 1'b0, 11'd18));
  endtask

  // Even rounds build, odd rounds probe with the width of the build before
  task automatic run_round(input int r);
    set_item_t it;
    logic      build;
    int        p;
    int        pick;
    build = (r % 2 == 0);
    set_idle((r + r / 4) % 4);
    drain();
    write_reg(CFG_PHASE, build ? 2'b00 : 2'b01);
    write_reg(CFG_KWIDTH, 2'(3 - (r / 2) % 4));
    repeat (build ? BUILD_ITEMS : PROBE_ITEMS) begin
      p    = $urandom_range(99);
      it   = mk(build ? KIND_INSERT : KIND_PROBE, rand_key(), fresh_hash(), 1'b0, rand_row());
      pick = (known_key.size() > 0) ? $urandom_range(known_key.size() - 1) : -1;
      if (build) begin
        if (p < 80 && p >= 62 && pick >= 0) begin
          it.key  = known_key[pick];
          it.hash = known_hash[pick];
        end else if (p < 86 && p >= 80 && pick >= 0) begin
          it.hash = known_hash[pick];
        end else if (p >= 93) begin
          it.kind = KIND_PROBE;
        end else if (p >= 86) begin
          it.is_null = 1'b1;
        end
        if (p < 86) begin
          known_key.insert(known_key.size(), it.key);
          known_hash.insert(known_hash.size(), it.hash);
        end
      end else begin
        if (p < 55 && pick >= 0) begin
          it.key  = known_key[pick];
          it.hash = known_hash[pick];
        end else if (p >= 75 && p < 85 && pick >= 0) begin
          it.hash = known_hash[pick];
        end else if (p >= 85 && p < 92) begin
          it.is_null = 1'b1;
        end else if (p >= 92) begin
          it.kind = KIND_INSERT;
        end
      end
      send_item(it);
    end
  endtask

  initial begin
    int r;
    board     = new();
    gap_pct   = 0;
    stall_pct = 0;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_PHASE;
    cfg_wdata <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.kind        <= KIND_INSERT;
    in_ch.key_value   <= '0;
    in_ch.key_hash    <= '0;
    in_ch.key_is_null <= 1'b0;
    in_ch.row_index   <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    for (r = 0; r < ROUNDS; r++)
      run_round(r);
    drain();
    repeat (20) @(posedge clk);
    if (board.pending() != 0)
      $display("%0d results never arrived", board.pending());
    if (board.fails == 0 && board.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
